// File: design/tlwm_pkg.sv
package tlwm_pkg;

    // table size
    localparam int ENTRY_COUNT = 8;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam int CNT_W   = 32;
    localparam int PCT_W   = 10;
    localparam int MASK_W  = 8;
    localparam int ID_W    = 8;
    localparam int QUOT_W  = 26;
    localparam int BOUND_W = QUOT_W + PCT_W;

    // x / 100 for any 32-bit x as (x * PCT_RECIP) >> PCT_SHIFT
    localparam logic [31:0] PCT_RECIP = 32'd1374389535;
    localparam int          PCT_SHIFT = 37;

    // register reset values
    localparam logic [31:0]       PERIOD_RST = 32'd8000;
    localparam logic [PCT_W-1:0]  MIN_RST    = 10'd70;
    localparam logic [PCT_W-1:0]  MAX_RST    = 10'd120;
    localparam logic [MASK_W-1:0] MASK_RST   = 8'd1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;
    localparam logic [1:0] REG_MASK   = 2'd3;

    // actions
    localparam logic [1:0] ACT_REPORT  = 2'd0;
    localparam logic [1:0] ACT_SUSPEND = 2'd1;
    localparam logic [1:0] ACT_RESUME  = 2'd2;
    localparam logic [1:0] ACT_CHECK   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_HALTED  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_CHK,
        ST_DONE
    } state_t;

endpackage

// File: design/task_liveness_window_monitor.sv
// Windowed task liveness monitor. A table of ENTRY_COUNT entries, each a 32-bit run-time
// counter and an inactive flag, lives in one synchronous memory (registered read,
// per-entry valid bits so reset clears it at once). A report adds amount to one counter
// with saturation; suspend/resume set/clear the inactive flag and clear the counter. A check
// walks the entries in order: a counter inside [(period/100)*min_pct, (period/100)*max_pct]
// (window [0,0] for entries not enabled) or an inactive entry is cleared; otherwise a sticky
// failure latches that entry and the walk stops. After a failure every transaction is
// ignored and answered with status 2. A report, suspend or resume with an id at or above
// ENTRY_COUNT answers status 1. Sequence: a report, suspend or resume reads the memory at
// the accepting edge, writes back, then loads the result register; a check does one memory
// read-modify-write per entry visited (at most ENTRY_COUNT) before the result register; an
// ignored or halted transaction goes straight to the result register. The state returns to
// idle at the edge that loads a result, so the input side is ready again then unless a
// register write holds it off. The result register lets the next transaction be accepted
// while a result waits for m_ready. The window bounds are computed from the registers by a
// two-stage multiplier pipeline, so the input side is held off after reset and after each
// register write until both stages have refreshed.
module task_liveness_window_monitor
    import tlwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [ID_W-1:0]   s_entry_id,
    input  logic [CNT_W-1:0]  s_amount,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_failed,
    output logic [ID_W-1:0]   m_failing_entry,
    output logic [1:0]        m_status
);

    // configuration registers
    logic [31:0]       period_reg;
    logic [PCT_W-1:0]  min_reg;
    logic [PCT_W-1:0]  max_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [1:0]        cfg_wait_reg;
    logic              cfg_wr;

    // window bound pipeline
    logic [63:0]        recip_prod;
    logic [QUOT_W-1:0]  quot_reg;
    logic [BOUND_W-1:0] lo_reg;
    logic [BOUND_W-1:0] hi_reg;

    // entry memory: {inactive, counter}
    logic [CNT_W:0]   mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] vld_reg;
    logic [CNT_W:0]   rdata_reg;
    logic             rvld_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [CNT_W:0]   wd;

    // sequencer
    state_t            state_reg, state_next;
    logic [1:0]        action_reg, action_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]  amount_reg, amount_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        status_reg, status_next;
    logic              halted_reg, halted_next;
    logic [ID_W-1:0]   halted_entry_reg, halted_entry_next;

    // result register
    logic              m_valid_reg;
    logic              m_failed_reg;
    logic [ID_W-1:0]   m_failing_entry_reg;
    logic [1:0]        m_status_reg;
    logic              out_load;

    // datapath helpers
    logic              s_accept;
    logic              id_oor;
    logic [CNT_W-1:0]  ent_cnt;
    logic              ent_inact;
    logic [CNT_W:0]    sum;
    logic [CNT_W-1:0]  sum_sat;
    logic [8:0]        idx_ext;
    logic              ent_en;
    logic [BOUND_W-1:0] lo_sel;
    logic [BOUND_W-1:0] hi_sel;
    logic [BOUND_W-1:0] cnt_ext;
    logic              ent_pass;
    logic              idx_last;

    // ---------------- register port ----------------

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RST;
            min_reg      <= MIN_RST;
            max_reg      <= MAX_RST;
            mask_reg     <= MASK_RST;
            cfg_wait_reg <= 2'd2;
        end else begin
            if (cfg_wr) begin
                cfg_wait_reg <= 2'd2;
                case (paddr[3:2])
                    REG_PERIOD: period_reg <= pwdata;
                    REG_MIN:    min_reg    <= pwdata[PCT_W-1:0];
                    REG_MAX:    max_reg    <= pwdata[PCT_W-1:0];
                    REG_MASK:   mask_reg   <= pwdata[MASK_W-1:0];
                    default:    ;
                endcase
            end else if (cfg_wait_reg != 2'd0) begin
                cfg_wait_reg <= cfg_wait_reg - 2'd1;
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PERIOD: prdata = period_reg;
            REG_MIN:    prdata = {{(32-PCT_W){1'b0}}, min_reg};
            REG_MAX:    prdata = {{(32-PCT_W){1'b0}}, max_reg};
            REG_MASK:   prdata = {{(32-MASK_W){1'b0}}, mask_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- window bounds ----------------

    // period / 100 by reciprocal multiply, then the two percent products
    assign recip_prod = 64'(period_reg) * 64'(PCT_RECIP);

    always_ff @(posedge aclk) begin
        quot_reg <= QUOT_W'(recip_prod >> PCT_SHIFT);
        lo_reg   <= BOUND_W'(quot_reg) * BOUND_W'(min_reg);
        hi_reg   <= BOUND_W'(quot_reg) * BOUND_W'(max_reg);
    end

    // ---------------- entry memory ----------------

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[wa] <= 1'b1;
            end
            rvld_reg <= vld_reg[rd_addr];
        end
    end

    // ---------------- entry evaluation ----------------

    assign ent_cnt   = rvld_reg ? rdata_reg[CNT_W-1:0] : '0;
    assign ent_inact = rvld_reg && rdata_reg[CNT_W];

    // saturating report add
    assign sum     = {1'b0, ent_cnt} + {1'b0, amount_reg};
    assign sum_sat = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

    // only the first eight entries have an enable bit
    assign idx_ext = 9'(idx_reg);
    assign ent_en  = (idx_ext < 9'd8) && mask_reg[idx_ext[2:0]];
    assign lo_sel  = ent_en ? lo_reg : '0;
    assign hi_sel  = ent_en ? hi_reg : '0;
    assign cnt_ext = BOUND_W'(ent_cnt);
    assign ent_pass = ((cnt_ext >= lo_sel) && (cnt_ext <= hi_sel)) || ent_inact;
    assign idx_last = (idx_ext == 9'(ENTRY_COUNT - 1));

    assign s_ready  = (state_reg == ST_IDLE) && (cfg_wait_reg == 2'd0);
    assign s_accept = s_valid && s_ready;
    assign id_oor   = {1'b0, s_entry_id} >= 9'(ENTRY_COUNT);
    assign out_load = !m_valid_reg || m_ready;

    // ---------------- sequencer: next state ----------------

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (halted_reg) begin
                        state_next = ST_DONE;
                    end else if (s_action == ACT_CHECK) begin
                        state_next = ST_CHK;
                    end else if (id_oor) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                state_next = ST_DONE;
            end
            ST_CHK: begin
                if (!ent_pass || idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------

    always_comb begin
        action_next       = action_reg;
        id_next           = id_reg;
        amount_next       = amount_reg;
        idx_next          = idx_reg;
        status_next       = status_reg;
        halted_next       = halted_reg;
        halted_entry_next = halted_entry_reg;
        rd_addr           = idx_reg + IDX_W'(1);
        we                = 1'b0;
        wa                = id_reg[IDX_W-1:0];
        wd                = '0;
        case (state_reg)
            ST_IDLE: begin
                rd_addr = (s_action == ACT_CHECK) ? '0 : s_entry_id[IDX_W-1:0];
                if (s_accept) begin
                    action_next = s_action;
                    id_next     = s_entry_id;
                    amount_next = s_amount;
                    idx_next    = '0;
                    if (halted_reg) begin
                        status_next = STAT_HALTED;
                    end else if (s_action != ACT_CHECK && id_oor) begin
                        status_next = STAT_IGNORED;
                    end else begin
                        status_next = STAT_DONE;
                    end
                end
            end
            ST_UPD: begin
                we = 1'b1;
                if (action_reg == ACT_REPORT) begin
                    wd = {ent_inact, sum_sat};
                end else begin
                    wd = {(action_reg == ACT_SUSPEND), {CNT_W{1'b0}}};
                end
            end
            ST_CHK: begin
                // write back entry idx while the next entry is read
                wa = idx_reg;
                if (ent_pass) begin
                    we       = 1'b1;
                    wd       = {ent_inact, {CNT_W{1'b0}}};
                    idx_next = idx_reg + IDX_W'(1);
                end else begin
                    halted_next       = 1'b1;
                    halted_entry_next = ID_W'(idx_reg);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            halted_reg       <= 1'b0;
            halted_entry_reg <= '0;
        end else begin
            state_reg        <= state_next;
            halted_reg       <= halted_next;
            halted_entry_reg <= halted_entry_next;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        id_reg     <= id_next;
        amount_reg <= amount_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    // ---------------- result register ----------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_load) begin
            m_failed_reg        <= halted_reg;
            m_failing_entry_reg <= halted_reg ? halted_entry_reg : '0;
            m_status_reg        <= status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_failed        = m_failed_reg;
    assign m_failing_entry = m_failing_entry_reg;
    assign m_status        = m_status_reg;

endmodule
